/* hw/rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 stream cipher core: state
// geometry, configuration register indexes, command codes and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cc20_pkg;

    // Cipher state geometry.
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 16;
    localparam int WORD_IDX_W = 4;
    localparam int BYTE_POS_W = 6;

    // Ten double rounds of eight quarter-rounds, one quarter-round per step.
    localparam int NUM_QR_STEPS = 80;
    localparam int STEP_W       = 7;

    // Step slots within a double round where the row rotation changes.
    localparam logic [2:0] COL_LAST_SLOT  = 3'd3;
    localparam logic [2:0] DIAG_LAST_SLOT = 3'd7;

    // Constant words of the initial state ("expand 32-byte k").
    localparam logic [WORD_W-1:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
    };

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;

    // Input command codes.
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    // Row rotation applied after a quarter-round step.
    typedef enum logic [1:0] {
        ROT_NORMAL    = 2'd0,
        ROT_COL_LAST  = 2'd1,
        ROT_DIAG_LAST = 2'd2
    } rot_mode_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      clear_counter;
        logic      consume_byte;
        logic      load_work;
        logic      qr_step;
        rot_mode_t rot_mode;
        logic      finish_block;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_byte;
    } dp_status_t;

endpackage

/* hw/rtl/cc20_in_if.sv */
// ----------------------------------------------------------------------------
// cc20_in_if
// Input channel: a command and a data byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cc20_in_if;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);

endinterface

/* hw/rtl/cc20_out_if.sv */
// ----------------------------------------------------------------------------
// cc20_out_if
// Output channel: one processed byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cc20_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);

endinterface

/* hw/rtl/cc20_datapath.sv */
// ----------------------------------------------------------------------------
// cc20_datapath
// Configuration registers, block counter, working state with one shared
// quarter-round unit, keystream store and the byte XOR output register.
// ----------------------------------------------------------------------------
module cc20_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  cc20_pkg::dp_cmd_t                cmd,
    input  logic [7:0]                       data_byte,
    output cc20_pkg::dp_status_t             status,
    output logic [7:0]                       out_byte
);

    localparam int W = cc20_pkg::WORD_W;
    localparam int N = cc20_pkg::NUM_WORDS;

    logic [cc20_pkg::CFG_DATA_W-1:0] key_reg [4];
    logic [cc20_pkg::CFG_DATA_W-1:0] nonce01_reg;
    logic [W-1:0]                    nonce2_reg;
    logic [W-1:0]                    counter_reg;
    logic [cc20_pkg::BYTE_POS_W-1:0] pos_reg;
    logic [W-1:0]                    work_reg [N];
    logic [W-1:0]                    work_next [N];
    logic [W-1:0]                    ks_reg [N];
    logic [7:0]                      out_byte_reg;

    logic [W-1:0] init_word [N];
    logic [W-1:0] qr_out [4];
    logic [W-1:0] ks_word;
    logic [7:0]   ks_byte;

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            nonce01_reg <= '0;
            nonce2_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cc20_pkg::CFG_KEY_01:   key_reg[0]  <= cfg_wr_data;
                cc20_pkg::CFG_KEY_23:   key_reg[1]  <= cfg_wr_data;
                cc20_pkg::CFG_KEY_45:   key_reg[2]  <= cfg_wr_data;
                cc20_pkg::CFG_KEY_67:   key_reg[3]  <= cfg_wr_data;
                cc20_pkg::CFG_NONCE_01: nonce01_reg <= cfg_wr_data;
                cc20_pkg::CFG_NONCE_2:  nonce2_reg  <= cfg_wr_data[W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Initial block state: constants, key, counter and nonce.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            init_word[k]         = cc20_pkg::SIGMA[k];
            init_word[4 + 2 * k] = key_reg[k][W-1:0];
            init_word[5 + 2 * k] = key_reg[k][2*W-1:W];
        end
        init_word[12] = counter_reg;
        init_word[13] = nonce01_reg[W-1:0];
        init_word[14] = nonce01_reg[2*W-1:W];
        init_word[15] = nonce2_reg;
    end

    // Quarter-round on column 0 of the four rows (words 0, 4, 8 and 12).
    always_comb
    begin
        logic [W-1:0] a1, a2, b1, b2, c1, c2, d1, d2, t;
        a1 = work_reg[0] + work_reg[4];
        t  = work_reg[12] ^ a1;
        d1 = {t[15:0], t[31:16]};
        c1 = work_reg[8] + d1;
        t  = work_reg[4] ^ c1;
        b1 = {t[19:0], t[31:20]};
        a2 = a1 + b1;
        t  = d1 ^ a2;
        d2 = {t[23:0], t[31:24]};
        c2 = c1 + d2;
        t  = b1 ^ c2;
        b2 = {t[24:0], t[31:25]};
        qr_out[0] = a2;
        qr_out[1] = b2;
        qr_out[2] = c2;
        qr_out[3] = d2;
    end

    // Row rotation after a step. Normally each row moves left by one word so
    // the next column comes to position 0. At the end of the column round
    // row r moves by 1+r, which lines the diagonals up as columns; at the end
    // of the diagonal round row r moves by 1-r, which restores the layout.
    always_comb
    begin
        logic [W-1:0] row_val [4];
        logic [1:0]   amt;
        for (int r = 0; r < 4; r++)
        begin
            unique case (cmd.rot_mode)
                cc20_pkg::ROT_COL_LAST:  amt = 2'(r + 1);
                cc20_pkg::ROT_DIAG_LAST: amt = 2'(1 - r);
                default:                 amt = 2'd1;
            endcase
            row_val[0] = qr_out[r];
            for (int i = 1; i < 4; i++)
            begin
                row_val[i] = work_reg[4 * r + i];
            end
            for (int i = 0; i < 4; i++)
            begin
                work_next[4 * r + i] = row_val[2'(i) + amt];
            end
        end
    end

    // Working state.
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            work_reg <= init_word;
        end
        else if (cmd.qr_step)
        begin
            work_reg <= work_next;
        end
    end

    // Keystream store, loaded with the feed-forward sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                ks_reg[k] <= '0;
            end
        end
        else if (cmd.finish_block)
        begin
            for (int k = 0; k < N; k++)
            begin
                ks_reg[k] <= work_reg[k] + init_word[k];
            end
        end
    end

    // Block counter and byte position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_counter)
            begin
                counter_reg <= '0;
            end
            else if (cmd.finish_block)
            begin
                counter_reg <= counter_reg + W'(1);
            end

            if (cmd.finish_block)
            begin
                pos_reg <= '0;
            end
            else if (cmd.consume_byte)
            begin
                pos_reg <= pos_reg + cc20_pkg::BYTE_POS_W'(1);
            end
        end
    end

    // Little-endian byte selection and XOR into the output register.
    assign ks_word = ks_reg[pos_reg[cc20_pkg::BYTE_POS_W-1:2]];

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    ks_byte = ks_word[7:0];
            2'd1:    ks_byte = ks_word[15:8];
            2'd2:    ks_byte = ks_word[23:16];
            default: ks_byte = ks_word[31:24];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.consume_byte)
        begin
            out_byte_reg <= data_byte ^ ks_byte;
        end
    end

    assign out_byte         = out_byte_reg;
    assign status.last_byte = &pos_reg;

endmodule

/* hw/rtl/cc20_ctrl.sv */
// ----------------------------------------------------------------------------
// cc20_ctrl
// Controller: input and output handshakes, block generation sequencing and
// the quarter-round step count.
// ----------------------------------------------------------------------------
module cc20_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    input  logic                  out_ready,
    input  cc20_pkg::dp_status_t  status,
    output logic                  in_ready,
    output logic                  out_valid,
    output cc20_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [cc20_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          in_fire;
    logic                          data_fire;

    // Input is taken only when idle and the output slot is free or freeing.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign data_fire = in_fire && (in_command == cc20_pkg::CMD_DATA);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.rot_mode = cc20_pkg::ROT_NORMAL;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_command == cc20_pkg::CMD_RESTART)
                    begin
                        cmd.clear_counter = 1'b1;
                        state_next        = ST_LOAD;
                    end
                    else
                    begin
                        cmd.consume_byte = 1'b1;
                        if (status.last_byte)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                step_next     = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.qr_step = 1'b1;
                if (step_reg[2:0] == cc20_pkg::COL_LAST_SLOT)
                begin
                    cmd.rot_mode = cc20_pkg::ROT_COL_LAST;
                end
                else if (step_reg[2:0] == cc20_pkg::DIAG_LAST_SLOT)
                begin
                    cmd.rot_mode = cc20_pkg::ROT_DIAG_LAST;
                end
                step_next = step_reg + cc20_pkg::STEP_W'(1);
                if (step_reg == cc20_pkg::STEP_W'(cc20_pkg::NUM_QR_STEPS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.finish_block = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (data_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/chacha20_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 (IETF, 96-bit nonce) keystream XOR engine, one byte per transfer.
// ----------------------------------------------------------------------------
// Key and nonce are written through the configuration port (registers 0 to
// 3 hold the key, 4 and 5 the nonce; other indexes are ignored) and are read
// when a block is generated. A restart command clears the block counter and
// generates block 0 without a result; a data command returns the byte XORed
// with the next keystream byte. A restart, and every 64th data byte, starts
// block generation, which holds off the input after the transfer while it
// loads the state, runs 80 steps of the single shared quarter-round unit and
// forms the feed-forward sum. The result waits in the output register, and
// input is held off while a result waits unaccepted.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    cc20_in_if.sink                          in_stream,
    cc20_out_if.source                       out_stream
);

    cc20_pkg::dp_cmd_t    dp_cmd;
    cc20_pkg::dp_status_t dp_status;

    // Sequencing and handshakes.
    cc20_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_stream.valid),
        .in_command (in_stream.command),
        .out_ready  (out_stream.ready),
        .status     (dp_status),
        .in_ready   (in_stream.ready),
        .out_valid  (out_stream.valid),
        .cmd        (dp_cmd)
    );

    // Cipher state and keystream.
    cc20_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (dp_cmd),
        .data_byte   (in_stream.data_byte),
        .status      (dp_status),
        .out_byte    (out_stream.out_byte)
    );

    // A data transfer always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stream.valid && in_stream.ready && in_stream.command == cc20_pkg::CMD_DATA)
        |=> out_stream.valid)
    else $error("data transfer did not produce a result");

    // A restart starts block generation, which holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stream.valid && in_stream.ready && in_stream.command == cc20_pkg::CMD_RESTART)
        |=> !in_stream.ready)
    else $error("input accepted during block generation");

    // Input is never taken while a result is stuck in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stream.ready |-> (!out_stream.valid || out_stream.ready))
    else $error("input ready while output is stalled");

endmodule
